// ----- design/slc_pkg.sv -----
package slc_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int CHAR_W          = 8;
	localparam int FIELD_W         = 32;
	localparam int RESULT_W        = 4 * FIELD_W;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SP    = 8'd32;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_SLASH,
		MODE_LINE,
		MODE_BLOCK,
		MODE_BSTAR
	} lex_mode_t;

	typedef enum logic [1:0] {
		CLS_BLANK,
		CLS_COMMENT,
		CLS_CODE
	} line_cls_t;

	// one queued event: end of a line and/or end of text
	typedef struct packed {
		logic      last;
		logic      line_end;
		line_cls_t cls;
	} slc_event_t;

endpackage

// ----- design/slc_front.sv -----
module slc_front import slc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] char_in,
	input  logic              end_of_text,
	input  logic              q_full,
	output logic              q_push,
	output slc_event_t        q_data
);

	lex_mode_t mode_q, mode_d;
	logic      code_q, code_d;
	logic      cmt_q, cmt_d;
	logic      accept;
	logic      is_nl;
	logic      solid;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_nl    = (char_in == CH_NL);
	assign solid    = (char_in != CH_SP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			code_q <= 1'b0;
			cmt_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			code_q <= code_d;
			cmt_q  <= cmt_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		code_d = code_q;
		cmt_d  = cmt_q;
		q_data.last     = end_of_text;
		q_data.line_end = is_nl;
		if (code_q || mode_q == MODE_SLASH)
			q_data.cls = CLS_CODE;
		else if (cmt_q)
			q_data.cls = CLS_COMMENT;
		else
			q_data.cls = CLS_BLANK;

		if (is_nl) begin
			case (mode_q)
				MODE_BSTAR, MODE_BLOCK: mode_d = MODE_BLOCK;
				default:                mode_d = MODE_NORMAL;
			endcase
			code_d = 1'b0;
			cmt_d  = 1'b0;
		end else begin
			case (mode_q)
				MODE_SLASH: begin
					if (char_in == CH_SLASH) begin
						mode_d = MODE_LINE;
						cmt_d  = 1'b1;
					end else if (char_in == CH_STAR) begin
						mode_d = MODE_BLOCK;
						cmt_d  = 1'b1;
					end else begin
						mode_d = MODE_NORMAL;
						code_d = 1'b1;
					end
				end
				MODE_LINE: begin
					if (solid)
						cmt_d = 1'b1;
				end
				MODE_BLOCK: begin
					if (solid)
						cmt_d = 1'b1;
					if (char_in == CH_STAR)
						mode_d = MODE_BSTAR;
				end
				MODE_BSTAR: begin
					if (solid)
						cmt_d = 1'b1;
					if (char_in == CH_SLASH)
						mode_d = MODE_NORMAL;
					else if (char_in != CH_STAR)
						mode_d = MODE_BLOCK;
				end
				default: begin
					mode_d = MODE_NORMAL;
					if (char_in == CH_SLASH)
						mode_d = MODE_SLASH;
					else if (solid)
						code_d = 1'b1;
				end
			endcase
		end

		// new text starts clean
		if (end_of_text) begin
			mode_d = MODE_NORMAL;
			code_d = 1'b0;
			cmt_d  = 1'b0;
		end
	end

	assign q_push = accept && (is_nl || end_of_text);

endmodule

// ----- design/slc_queue.sv -----
module slc_queue import slc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  slc_event_t push_data,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output slc_event_t head
);

	slc_event_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0]       wr_ptr_q;
	logic [Q_AW-1:0]       rd_ptr_q;
	logic [Q_CW-1:0]       count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full       = (count_q == Q_CW'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- design/slc_back.sv -----
module slc_back import slc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ev_valid,
	input  slc_event_t          ev,
	output logic                ev_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RESULT_W-1:0] out_data
);

	localparam int XW = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W + 1;

	function automatic logic [FIELD_W-1:0] clip(input logic [COUNT_WIDTH-1:0] v);
		logic [XW-1:0] ext;
		ext = XW'(v);
		if (|ext[XW-1:FIELD_W])
			return '1;
		return ext[FIELD_W-1:0];
	endfunction

	logic [COUNT_WIDTH-1:0] total_q, blank_q, cmt_q;
	logic [COUNT_WIDTH-1:0] total_n, blank_n, cmt_n;

	logic               valid_s1, valid_s2, valid_q;
	logic [FIELD_W-1:0] total_s1, blank_s1, cmt_s1;
	logic [FIELD_W-1:0] total_s2, blank_s2, cmt_s2;
	logic [FIELD_W:0]   used_s2;
	logic [FIELD_W-1:0] total_q2, blank_q2, cmt_q2, code_q2;
	logic [FIELD_W+1:0] diff;
	logic               ready_q, ready_s2, ready_s1;

	assign ready_q  = !valid_q || out_ready;
	assign ready_s2 = !valid_s2 || ready_q;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign ev_pop   = ev_valid && (!ev.last || ready_s1);

	always_comb begin
		total_n = total_q;
		blank_n = blank_q;
		cmt_n   = cmt_q;
		if (ev.line_end) begin
			if (total_q != '1)
				total_n = total_q + 1'b1;
			if (ev.cls == CLS_BLANK && blank_q != '1)
				blank_n = blank_q + 1'b1;
			if (ev.cls == CLS_COMMENT && cmt_q != '1)
				cmt_n = cmt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			blank_q <= '0;
			cmt_q   <= '0;
		end else if (ev_pop) begin
			if (ev.last) begin
				total_q <= '0;
				blank_q <= '0;
				cmt_q   <= '0;
			end else begin
				total_q <= total_n;
				blank_q <= blank_n;
				cmt_q   <= cmt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= ev_pop && ev.last;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_q)
				valid_q <= valid_s2;
		end
	end

	assign diff = {1'b0, total_s2, 1'b0} - {used_s2, 1'b0};

	always_ff @(posedge clk) begin
		if (ready_s1 && ev_pop && ev.last) begin
			total_s1 <= clip(total_n);
			blank_s1 <= clip(blank_n);
			cmt_s1   <= clip(cmt_n);
		end
		if (ready_s2 && valid_s1) begin
			total_s2 <= total_s1;
			blank_s2 <= blank_s1;
			cmt_s2   <= cmt_s1;
			used_s2  <= {1'b0, blank_s1} + {1'b0, cmt_s1};
		end
		if (ready_q && valid_s2) begin
			total_q2 <= total_s2;
			blank_q2 <= blank_s2;
			cmt_q2   <= cmt_s2;
			code_q2  <= diff[FIELD_W+1] ? '0 : diff[FIELD_W:1];
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {code_q2, cmt_q2, blank_q2, total_q2};

endmodule

// ----- design/source_line_classifier.sv -----
// Line classifier for C source text. Takes one byte per word on s_axis and sustains
// one byte per clock while the event queue is not full; the lexer step in the front
// end sets that rate, and the four-entry event queue lets it keep taking bytes while
// the result is stalled, until it fills. Each newline closes a line, counted as
// blank (spaces only), comment or code. The word with tlast set ends the text: its
// counts go to m_axis through the registered steps queue pop and clip, class sum
// and subtract, later while older line events wait, and all counts restart from zero.
// Counters are COUNT_WIDTH bits and saturate; outputs clip at 32 bits.
module source_line_classifier import slc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [CHAR_W-1:0]   s_axis_tdata,  // [7:0] char_in
	input  logic                s_axis_tlast,  // end_of_text
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [31:0] total_lines, [63:32] blank_lines, [95:64] comment_lines, [127:96] code_lines
	output logic [RESULT_W-1:0] m_axis_tdata
);

	logic       q_push, q_full, q_pop, q_valid;
	slc_event_t q_in, q_head;

	slc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.char_in     (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	slc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	slc_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (q_valid),
		.ev        (q_head),
		.ev_pop    (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ----- design/slc_checker.sv -----
module slc_checker import slc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [RESULT_W-1:0] m_axis_tdata
);

	logic [FIELD_W-1:0] total, blank, cmt, code;
	logic [FIELD_W+1:0] sum;

	assign total = m_axis_tdata[FIELD_W-1:0];
	assign blank = m_axis_tdata[2*FIELD_W-1:FIELD_W];
	assign cmt   = m_axis_tdata[3*FIELD_W-1:2*FIELD_W];
	assign code  = m_axis_tdata[4*FIELD_W-1:3*FIELD_W];
	assign sum   = (FIELD_W+2)'(code) + (FIELD_W+2)'(blank) + (FIELD_W+2)'(cmt);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_class_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (code == '0) || (sum == (FIELD_W+2)'(total)))
		else $error("line classes do not add up to total");

	a_class_le: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (blank <= total) && (cmt <= total))
		else $error("class count exceeds total");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_axis_tvalid) |-> $past(m_axis_tready))
		else $error("result word dropped without handshake");

endmodule

bind source_line_classifier slc_checker u_slc_checker (.*);
